>>> rtl/i2c_master_byte_engine_assert.svh
// assertion macros for the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // command codes carried in the mode field
    localparam logic [3:0] MODE_TICK  = 4'd0;
    localparam logic [3:0] MODE_START = 4'd1;
    localparam logic [3:0] MODE_STOP  = 4'd2;
    localparam logic [3:0] MODE_WRITE = 4'd3;
    localparam logic [3:0] MODE_READ  = 4'd4;
    localparam logic [3:0] MODE_ACK   = 4'd5;
    localparam logic [3:0] MODE_NACK  = 4'd6;
    localparam logic [3:0] MODE_RDACK = 4'd7;
    localparam logic [3:0] MODE_PROBE = 4'd8;

    // configuration register indexes
    localparam logic CFG_IDX_PHASE   = 1'b0;
    localparam logic CFG_IDX_RELEASE = 1'b1;

    // reset values and fixed constants
    localparam logic [15:0] PHASE_TICKS_RESET   = 16'd5;
    localparam logic [15:0] RELEASE_TICKS_RESET = 16'd100;
    localparam logic [2:0]  BIT_TOP             = 3'd7;
    localparam logic [7:0]  BYTE_ZERO           = 8'h00;

    // one tick request
    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] tx_byte;
        logic       sda_in;
    } cmd_t;

    // one result request
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
    } res_t;

    // timing configuration handed to the sequencer
    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [15:0] release_ticks;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/i2cm_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic acc,
    input  wire cmd_t cmd,
    input  wire cfg_t cfg,
    output res_t      res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D, PH_SP_E,
        PH_WR_A, PH_WR_LOW, PH_WR_DATA, PH_WR_HIGH, PH_WR_END,
        PH_RD_A, PH_RD_HIGH, PH_RD_LOW, PH_AK_A, PH_AK_B, PH_AK_C,
        PH_RA_HIGH, PH_RA_LOW
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  command_reg, command_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] wait_reg, wait_next;
    logic        scl_lv_reg, scl_lv_next;
    logic        sda_lv_reg, sda_lv_next;
    logic        scl_dr_reg, scl_dr_next;
    logic        sda_dr_reg, sda_dr_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_reg, ack_next;

    logic        done;
    logic        enter;
    phase_t      ent_ph;
    logic [15:0] hold;

    // next state for one tick
    always_comb
    begin
        phase_next   = phase_reg;
        command_next = command_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        wait_next    = wait_reg;
        scl_lv_next  = scl_lv_reg;
        sda_lv_next  = sda_lv_reg;
        scl_dr_next  = scl_dr_reg;
        sda_dr_next  = sda_dr_reg;
        rx_next      = rx_reg;
        ack_next     = ack_reg;
        done         = 1'b0;
        enter        = 1'b0;
        ent_ph       = PH_IDLE;
        hold         = cfg.phase_ticks;

        if (phase_reg == PH_IDLE)
        begin
            // command decode while idle
            unique case (cmd.mode) inside
                MODE_START, MODE_PROBE: begin enter = 1'b1; ent_ph = PH_ST_A;    end
                MODE_STOP:              begin enter = 1'b1; ent_ph = PH_SP_A;    end
                MODE_WRITE:             begin enter = 1'b1; ent_ph = PH_WR_A;    end
                MODE_READ:              begin enter = 1'b1; ent_ph = PH_RD_A;    end
                MODE_ACK, MODE_NACK:    begin enter = 1'b1; ent_ph = PH_AK_A;    end
                MODE_RDACK:             begin enter = 1'b1; ent_ph = PH_RA_HIGH; end
                default:                begin enter = 1'b0; ent_ph = PH_IDLE;    end
            endcase
            if (enter)
            begin
                command_next = cmd.mode;
                bit_next     = BIT_TOP;
                shift_next   = (cmd.mode == MODE_WRITE || cmd.mode == MODE_PROBE)
                               ? cmd.tx_byte : BYTE_ZERO;
            end
        end
        else if (wait_reg != 16'd0)
        begin
            wait_next = wait_reg - 16'd1;
        end
        else
        begin
            // end of the current phase, samples and successor
            unique case (phase_reg)
                PH_ST_A:    ent_ph = PH_ST_B;
                PH_ST_B:    ent_ph = (command_reg == MODE_PROBE) ? PH_WR_A : PH_IDLE;
                PH_SP_A:    ent_ph = PH_SP_B;
                PH_SP_B:    ent_ph = PH_SP_C;
                PH_SP_C:    ent_ph = PH_SP_D;
                PH_SP_D:    ent_ph = PH_SP_E;
                PH_WR_A:    ent_ph = PH_WR_LOW;
                PH_WR_LOW:  ent_ph = PH_WR_DATA;
                PH_WR_DATA: ent_ph = PH_WR_HIGH;
                PH_WR_HIGH:
                begin
                    if (bit_reg == 3'd0)
                        ent_ph = PH_WR_END;
                    else
                    begin
                        bit_next = bit_reg - 3'd1;
                        ent_ph   = PH_WR_LOW;
                    end
                end
                PH_WR_END:  ent_ph = (command_reg == MODE_PROBE) ? PH_RA_HIGH : PH_IDLE;
                PH_RD_A:    ent_ph = PH_RD_HIGH;
                PH_RD_HIGH:
                begin
                    shift_next = {shift_reg[6:0], cmd.sda_in};
                    ent_ph     = PH_RD_LOW;
                end
                PH_RD_LOW:
                begin
                    if (bit_reg == 3'd0)
                    begin
                        rx_next = shift_reg;
                        ent_ph  = PH_IDLE;
                    end
                    else
                    begin
                        bit_next = bit_reg - 3'd1;
                        ent_ph   = PH_RD_HIGH;
                    end
                end
                PH_AK_A:    ent_ph = PH_AK_B;
                PH_AK_B:    ent_ph = PH_AK_C;
                PH_RA_HIGH:
                begin
                    ack_next = cmd.sda_in;
                    ent_ph   = PH_RA_LOW;
                end
                default:    ent_ph = PH_IDLE;
            endcase
            if (ent_ph == PH_IDLE)
            begin
                phase_next = PH_IDLE;
                wait_next  = 16'd0;
                done       = 1'b1;
            end
            else
                enter = 1'b1;
        end

        // pin updates on phase entry
        if (enter)
        begin
            phase_next = ent_ph;
            unique case (ent_ph)
                PH_ST_A:
                begin
                    scl_dr_next = 1'b1; sda_dr_next = 1'b1;
                    scl_lv_next = 1'b1; sda_lv_next = 1'b1;
                end
                PH_ST_B:    sda_lv_next = 1'b0;
                PH_SP_A:    begin scl_dr_next = 1'b1; sda_dr_next = 1'b1; end
                PH_SP_B:    begin scl_lv_next = 1'b0; sda_lv_next = 1'b0; end
                PH_SP_C:    scl_lv_next = 1'b1;
                PH_SP_D:    sda_lv_next = 1'b1;
                PH_SP_E:
                begin
                    scl_dr_next = 1'b0; sda_dr_next = 1'b0;
                    hold        = cfg.release_ticks;
                end
                PH_WR_A:    begin scl_dr_next = 1'b1; sda_dr_next = 1'b1; end
                PH_WR_LOW:  scl_lv_next = 1'b0;
                PH_WR_DATA: sda_lv_next = shift_next[bit_next];
                PH_WR_HIGH: scl_lv_next = 1'b1;
                PH_WR_END:  scl_lv_next = 1'b0;
                PH_RD_A:    sda_dr_next = 1'b0;
                PH_RD_HIGH: begin sda_dr_next = 1'b0; scl_lv_next = 1'b1; end
                PH_RD_LOW:  scl_lv_next = 1'b0;
                PH_AK_A:
                begin
                    sda_dr_next = 1'b1; scl_lv_next = 1'b0;
                    sda_lv_next = (command_next == MODE_NACK);
                end
                PH_AK_B:    scl_lv_next = 1'b1;
                PH_AK_C:    scl_lv_next = 1'b0;
                PH_RA_HIGH: begin sda_dr_next = 1'b0; scl_lv_next = 1'b1; end
                PH_RA_LOW:  scl_lv_next = 1'b0;
                default:    hold = 16'd0;
            endcase
            // zero hold behaves as a one tick hold
            wait_next = (hold == 16'd0) ? 16'd0 : hold - 16'd1;
        end
    end

    // state after the tick as the result
    always_comb
    begin
        res.scl_level = scl_lv_next;
        res.sda_level = sda_lv_next;
        res.scl_drive = scl_dr_next;
        res.sda_drive = sda_dr_next;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.rx_byte   = rx_next;
        res.ack_bit   = ack_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            command_reg <= MODE_TICK;
            bit_reg     <= BIT_TOP;
            shift_reg   <= BYTE_ZERO;
            wait_reg    <= 16'd0;
            scl_lv_reg  <= 1'b1;
            sda_lv_reg  <= 1'b1;
            scl_dr_reg  <= 1'b1;
            sda_dr_reg  <= 1'b1;
            rx_reg      <= BYTE_ZERO;
            ack_reg     <= 1'b1;
        end
        else if (acc)
        begin
            phase_reg   <= phase_next;
            command_reg <= command_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            wait_reg    <= wait_next;
            scl_lv_reg  <= scl_lv_next;
            sda_lv_reg  <= sda_lv_next;
            scl_dr_reg  <= scl_dr_next;
            sda_dr_reg  <= sda_dr_next;
            rx_reg      <= rx_next;
            ack_reg     <= ack_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2cm_resq.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cm_resq
    import i2cm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t push_data,
    output logic      full,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    localparam logic [1:0] DEPTH = 2'd2;

    res_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == DEPTH);
    assign res_valid = (count_reg != 2'd0);
    assign res       = mem[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> rtl/i2c_master_byte_engine.sv
// channel   direction  handshake               payload
// cmd       in         cmd_valid / cmd_stall   cmd_t   (mode, tx_byte, sda_in)
// res       out        res_valid / res_stall   res_t   (pins, busy, done, rx, ack)
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one tick request taken per cycle while cmd_stall is low; the sequencer updates its whole state
// in the same cycle, and each result enters the result queue with its tick
// results pass through a two entry queue; cmd_stall rises only when it is full
// cfg_ready is always high, writes land on the next edge
// reset: bus idle, both lines high and driven, timing back to 5 and 100 ticks
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_byte_engine_assert.svh"

module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire cmd_t        cmd,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_t             res,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] phase_ticks_reg;
    logic [15:0] release_ticks_reg;
    cfg_t        cfg;
    res_t        seq_res;
    logic        acc;
    logic        full;

    assign cfg_ready = 1'b1;
    assign cmd_stall = full;
    assign acc       = cmd_valid && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg   <= PHASE_TICKS_RESET;
            release_ticks_reg <= RELEASE_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_PHASE:   phase_ticks_reg   <= cfg_data;
                CFG_IDX_RELEASE: release_ticks_reg <= cfg_data;
                default:         phase_ticks_reg   <= phase_ticks_reg;
            endcase
        end
    end

    assign cfg.phase_ticks   = phase_ticks_reg;
    assign cfg.release_ticks = release_ticks_reg;

    // bus sequencer
    i2cm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .cmd   (cmd),
        .cfg   (cfg),
        .res   (seq_res)
    );

    // result queue
    i2cm_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (acc),
        .push_data (seq_res),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // checks
    `I2CM_ASSERT_NOW(a_stall_needs_result, cmd_stall, res_valid,
        "request stalled with no result waiting")
    `I2CM_ASSERT_NEXT(a_tick_gives_result, cmd_valid && !cmd_stall, res_valid,
        "accepted tick left no result")
    `I2CM_ASSERT_NOW(a_done_not_busy, res_valid && res.done_res, !res.busy_res,
        "done reported while still busy")
    `I2CM_ASSERT_NEXT(a_cfg_write_lands, cfg_valid && cfg_ready && cfg_index == CFG_IDX_PHASE,
        phase_ticks_reg == $past(cfg_data), "phase tick write lost")

endmodule

`default_nettype wire

>>> tb/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_GAP       = 16;
    localparam int REPORT_LIMIT  = 40;
    localparam int RESET_CYCLES  = 7;

    localparam logic [3:0]  MODE_LAST  = 4'd15;
    localparam logic [3:0]  MODE_ODD   = 4'd9;
    localparam logic [15:0] TICKS_ZERO = 16'd0;
    localparam logic [15:0] TICKS_ONE  = 16'd1;
    localparam logic [15:0] TICKS_TWO  = 16'd2;
    localparam logic [15:0] TICKS_LONG = 16'd64;

    // sequencer phases of the predictor
    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_START_HIGH, SQ_START_LOW,
        SQ_STOP_DRIVE, SQ_STOP_LOW, SQ_STOP_SCL, SQ_STOP_SDA, SQ_STOP_RELEASE,
        SQ_WR_DRIVE, SQ_WR_LOW, SQ_WR_DATA, SQ_WR_HIGH, SQ_WR_END,
        SQ_RD_RELEASE, SQ_RD_HIGH, SQ_RD_LOW,
        SQ_ACK_DRIVE, SQ_ACK_HIGH, SQ_ACK_LOW,
        SQ_RA_HIGH, SQ_RA_LOW
    } seq_phase_t;

    // how the data line behaves while a command runs
    typedef enum int {SDA_ZERO, SDA_ONE, SDA_RAND} sda_kind_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd_item  = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_t        res_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data  = '0;

    i2c_master_byte_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted bus state per accepted tick
    res_t expected_bus[$];
    int   error_count = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;
    bit   send_idle   = 1'b1;
    bit   recv_idle   = 1'b1;
    int   res_wait    = 0;
    logic hold_on     = 1'b0;
    bit   hold_go     = 1'b0;
    bit   hold_seen   = 1'b0;
    int   hold_len    = 0;
    int   hold_count  = 0;

    // predictor state
    logic [15:0] cfg_phase_ticks;
    logic [15:0] cfg_release_ticks;
    seq_phase_t  seq_phase;
    logic [3:0]  seq_cmd;
    logic [2:0]  seq_bit;
    logic [7:0]  seq_shift;
    logic [15:0] seq_wait;
    logic        pin_scl, pin_sda, drv_scl, drv_sda;
    logic [7:0]  seq_rx;
    logic        seq_ack;

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // long hold-off of the result side, counted here
    always @(posedge clk)
    begin
        if (hold_go != hold_seen)
        begin
            hold_seen = hold_go;
            hold_count = hold_len;
        end
        else if (hold_count > 0)
        begin
            hold_count = hold_count - 1;
        end
        hold_on <= (hold_count != 0);
    end

    // result side: check each result, then a random stall
    always @(posedge clk)
    begin
        if (res_valid === 1'b1 && !res_stall)
        begin
            check_bus_state(res_item);
            res_wait = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
        else if (res_wait > 0)
        begin
            res_wait = res_wait - 1;
        end
        res_stall <= (res_wait != 0) || hold_on;
    end

    task automatic bus_reset();
        cfg_phase_ticks   = PHASE_TICKS_RESET;
        cfg_release_ticks = RELEASE_TICKS_RESET;
        seq_phase = SQ_IDLE;
        seq_cmd   = MODE_TICK;
        seq_bit   = BIT_TOP;
        seq_shift = BYTE_ZERO;
        seq_wait  = '0;
        pin_scl   = 1'b1;
        pin_sda   = 1'b1;
        drv_scl   = 1'b1;
        drv_sda   = 1'b1;
        seq_rx    = BYTE_ZERO;
        seq_ack   = 1'b1;
    endtask

    // set the pins of a new phase and load its hold count
    function automatic void seq_enter(input seq_phase_t p);
        logic [15:0] hold;
        hold = cfg_phase_ticks;
        seq_phase = p;
        case (p)
            SQ_START_HIGH:
            begin
                drv_scl = 1'b1;
                drv_sda = 1'b1;
                pin_scl = 1'b1;
                pin_sda = 1'b1;
            end
            SQ_START_LOW: pin_sda = 1'b0;
            SQ_STOP_DRIVE, SQ_WR_DRIVE:
            begin
                drv_scl = 1'b1;
                drv_sda = 1'b1;
            end
            SQ_STOP_LOW:
            begin
                pin_scl = 1'b0;
                pin_sda = 1'b0;
            end
            SQ_STOP_SCL: pin_scl = 1'b1;
            SQ_STOP_SDA: pin_sda = 1'b1;
            SQ_STOP_RELEASE:
            begin
                drv_scl = 1'b0;
                drv_sda = 1'b0;
                hold = cfg_release_ticks;
            end
            SQ_WR_LOW, SQ_WR_END, SQ_RD_LOW, SQ_ACK_LOW, SQ_RA_LOW: pin_scl = 1'b0;
            SQ_WR_DATA: pin_sda = seq_shift[seq_bit];
            SQ_WR_HIGH, SQ_ACK_HIGH: pin_scl = 1'b1;
            SQ_RD_RELEASE: drv_sda = 1'b0;
            SQ_RD_HIGH, SQ_RA_HIGH:
            begin
                drv_sda = 1'b0;
                pin_scl = 1'b1;
            end
            SQ_ACK_DRIVE:
            begin
                drv_sda = 1'b1;
                pin_scl = 1'b0;
                pin_sda = (seq_cmd == MODE_NACK);
            end
            default:
            begin
                seq_phase = SQ_IDLE;
                hold = TICKS_ZERO;
            end
        endcase
        seq_wait = (hold == TICKS_ZERO) ? TICKS_ZERO : hold - TICKS_ONE;
    endfunction

    // close the current phase, sampling sda where due; idle when finished
    function automatic seq_phase_t seq_leave(input logic sda);
        case (seq_phase)
            SQ_START_HIGH: return SQ_START_LOW;
            SQ_START_LOW:  return (seq_cmd == MODE_PROBE) ? SQ_WR_DRIVE : SQ_IDLE;
            SQ_STOP_DRIVE: return SQ_STOP_LOW;
            SQ_STOP_LOW:   return SQ_STOP_SCL;
            SQ_STOP_SCL:   return SQ_STOP_SDA;
            SQ_STOP_SDA:   return SQ_STOP_RELEASE;
            SQ_WR_DRIVE:   return SQ_WR_LOW;
            SQ_WR_LOW:     return SQ_WR_DATA;
            SQ_WR_DATA:    return SQ_WR_HIGH;
            SQ_WR_HIGH:
            begin
                if (seq_bit == 3'd0)
                    return SQ_WR_END;
                seq_bit = seq_bit - 3'd1;
                return SQ_WR_LOW;
            end
            SQ_WR_END:     return (seq_cmd == MODE_PROBE) ? SQ_RA_HIGH : SQ_IDLE;
            SQ_RD_RELEASE: return SQ_RD_HIGH;
            SQ_RD_HIGH:
            begin
                seq_shift = {seq_shift[6:0], sda};
                return SQ_RD_LOW;
            end
            SQ_RD_LOW:
            begin
                if (seq_bit == 3'd0)
                begin
                    seq_rx = seq_shift;
                    return SQ_IDLE;
                end
                seq_bit = seq_bit - 3'd1;
                return SQ_RD_HIGH;
            end
            SQ_ACK_DRIVE:  return SQ_ACK_HIGH;
            SQ_ACK_HIGH:   return SQ_ACK_LOW;
            SQ_RA_HIGH:
            begin
                seq_ack = sda;
                return SQ_RA_LOW;
            end
            default:       return SQ_IDLE;
        endcase
    endfunction

    // advance the predictor by one tick and give the bus state after it
    function automatic res_t bus_tick(input cmd_t c);
        res_t       r;
        seq_phase_t nxt;
        logic       fin;
        fin = 1'b0;
        if (seq_phase == SQ_IDLE)
        begin
            if (c.mode >= MODE_START && c.mode <= MODE_PROBE)
            begin
                seq_cmd = c.mode;
                seq_bit = BIT_TOP;
                seq_shift = (c.mode == MODE_WRITE || c.mode == MODE_PROBE) ?
                            c.tx_byte : BYTE_ZERO;
                case (c.mode)
                    MODE_START, MODE_PROBE: seq_enter(SQ_START_HIGH);
                    MODE_STOP:              seq_enter(SQ_STOP_DRIVE);
                    MODE_WRITE:             seq_enter(SQ_WR_DRIVE);
                    MODE_READ:              seq_enter(SQ_RD_RELEASE);
                    MODE_ACK, MODE_NACK:    seq_enter(SQ_ACK_DRIVE);
                    default:                seq_enter(SQ_RA_HIGH);
                endcase
            end
        end
        else if (seq_wait != TICKS_ZERO)
        begin
            seq_wait = seq_wait - TICKS_ONE;
        end
        else
        begin
            nxt = seq_leave(c.sda_in);
            if (nxt == SQ_IDLE)
            begin
                seq_phase = SQ_IDLE;
                seq_wait = TICKS_ZERO;
                fin = 1'b1;
            end
            else
            begin
                seq_enter(nxt);
            end
        end
        r.scl_level = pin_scl;
        r.sda_level = pin_sda;
        r.scl_drive = drv_scl;
        r.sda_drive = drv_sda;
        r.busy_res  = (seq_phase != SQ_IDLE);
        r.done_res  = fin;
        r.rx_byte   = seq_rx;
        r.ack_bit   = seq_ack;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            if (error_count < REPORT_LIMIT)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_bus_state(input res_t got);
        res_t want;
        if (expected_bus.size() == 0)
        begin
            if (error_count < REPORT_LIMIT)
                $display("%0t: unexpected result %p", $time, got);
            error_count++;
            return;
        end
        want = expected_bus.pop_front();
        compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
        compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
        compare_field("scl_drive", 8'(want.scl_drive), 8'(got.scl_drive));
        compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
        compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
        compare_field("rx_byte", want.rx_byte, got.rx_byte);
        compare_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
    endtask

    // offer one tick request and predict its result once taken
    task automatic send_tick(input cmd_t item);
        int gap;
        gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_item <= item;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        expected_bus.push_back(bus_tick(item));
        items_sent++;
    endtask

    function automatic logic pick_sda(input sda_kind_t kind);
        case (kind)
            SDA_ZERO: return 1'b0;
            SDA_ONE:  return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // issue a command and tick until the sequencer is idle again
    task automatic run_cmd(input logic [3:0] mode, input logic [7:0] tx,
                           input sda_kind_t sda_kind, input bit noisy);
        cmd_t item;
        item.mode = mode;
        item.tx_byte = tx;
        item.sda_in = pick_sda(sda_kind);
        send_tick(item);
        while (seq_phase != SQ_IDLE)
        begin
            item.mode = noisy ? 4'($urandom_range(0, MODE_LAST)) : MODE_TICK;
            item.tx_byte = noisy ? 8'($urandom) : BYTE_ZERO;
            item.sda_in = pick_sda(sda_kind);
            send_tick(item);
        end
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_bus.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_PHASE)
            cfg_phase_ticks = value;
        else
            cfg_release_ticks = value;
        @(posedge clk);
    endtask

    task automatic start_hold(input int cycles);
        hold_len <= cycles;
        hold_go <= ~hold_go;
    endtask

    // idle bus after reset and timing at reset values
    task automatic test_reset_state();
        run_cmd(MODE_TICK, BYTE_ZERO, SDA_ZERO, 1'b0);
        run_cmd(MODE_TICK, 8'hFF, SDA_ONE, 1'b0);
        run_cmd(MODE_START, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, 1'b0);
        settle();
    endtask

    // every command at least once, byte and ack extremes, unknown modes, busy noise
    task automatic test_commands();
        write_cfg(CFG_IDX_PHASE, TICKS_ONE);
        write_cfg(CFG_IDX_RELEASE, TICKS_TWO);
        run_cmd(MODE_START, BYTE_ZERO, SDA_ONE, 1'b0);
        run_cmd(MODE_WRITE, 8'hFF, SDA_ONE, 1'b0);
        run_cmd(MODE_RDACK, BYTE_ZERO, SDA_ZERO, 1'b0);
        run_cmd(MODE_WRITE, BYTE_ZERO, SDA_ZERO, 1'b0);
        run_cmd(MODE_RDACK, BYTE_ZERO, SDA_ONE, 1'b0);
        run_cmd(MODE_READ, BYTE_ZERO, SDA_ONE, 1'b0);
        run_cmd(MODE_ACK, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_READ, 8'hFF, SDA_ZERO, 1'b0);
        run_cmd(MODE_NACK, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_READ, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_PROBE, 8'hA5, SDA_ZERO, 1'b0);
        run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_PROBE, 8'h5A, SDA_ONE, 1'b0);
        run_cmd(MODE_ODD, 8'hFF, SDA_ONE, 1'b0);
        run_cmd(MODE_LAST, BYTE_ZERO, SDA_ZERO, 1'b0);
        // commands offered while busy must be ignored
        run_cmd(MODE_WRITE, 8'h3C, SDA_RAND, 1'b1);
        run_cmd(MODE_READ, BYTE_ZERO, SDA_RAND, 1'b1);
        run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, 1'b1);
        settle();
    endtask

    // zero hold counts behave as one tick
    task automatic test_zero_hold();
        write_cfg(CFG_IDX_PHASE, TICKS_ZERO);
        write_cfg(CFG_IDX_RELEASE, TICKS_ZERO);
        run_cmd(MODE_START, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_WRITE, 8'($urandom), SDA_RAND, 1'b0);
        run_cmd(MODE_READ, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_NACK, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_PROBE, 8'($urandom), SDA_RAND, 1'b0);
        settle();
    endtask

    // long hold counts, run back to back without idling
    task automatic test_longest_hold();
        send_idle = 1'b0;
        recv_idle <= 1'b0;
        write_cfg(CFG_IDX_PHASE, TICKS_LONG);
        run_cmd(MODE_START, BYTE_ZERO, SDA_RAND, 1'b0);
        settle();
        write_cfg(CFG_IDX_PHASE, TICKS_ONE);
        write_cfg(CFG_IDX_RELEASE, TICKS_LONG);
        run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, 1'b0);
        settle();
        send_idle = 1'b1;
        recv_idle <= 1'b1;
    endtask

    // result side held off while ticks keep coming, then drain and resume
    task automatic test_backpressure();
        send_idle = 1'b0;
        write_cfg(CFG_IDX_RELEASE, TICKS_TWO);
        start_hold(150);
        run_cmd(MODE_START, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_WRITE, 8'($urandom), SDA_RAND, 1'b0);
        run_cmd(MODE_RDACK, BYTE_ZERO, SDA_RAND, 1'b0);
        settle();
        run_cmd(MODE_READ, BYTE_ZERO, SDA_RAND, 1'b1);
        run_cmd(MODE_NACK, BYTE_ZERO, SDA_RAND, 1'b0);
        run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, 1'b0);
        settle();
        send_idle = 1'b1;
    endtask

    // one bus transaction: mostly well formed, sometimes noise or no stop
    task automatic random_transfer();
        int  nbytes;
        bit  noisy;
        bit  reading;
        if ($urandom_range(0, 9) == 0)
        begin
            run_cmd(4'($urandom_range(0, MODE_LAST)), 8'($urandom), SDA_RAND,
                    1'($urandom_range(0, 1)));
            return;
        end
        noisy = ($urandom_range(0, 3) == 0);
        reading = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1))
        begin
            run_cmd(MODE_PROBE, 8'($urandom), SDA_RAND, noisy);
        end
        else
        begin
            run_cmd(MODE_START, BYTE_ZERO, SDA_RAND, noisy);
            run_cmd(MODE_WRITE, 8'($urandom), SDA_RAND, noisy);
            run_cmd(MODE_RDACK, BYTE_ZERO, SDA_RAND, noisy);
        end
        nbytes = $urandom_range(0, 3);
        for (int i = 0; i < nbytes; i++)
        begin
            if (reading)
            begin
                run_cmd(MODE_READ, 8'($urandom), SDA_RAND, noisy);
                run_cmd((i == nbytes - 1) ? MODE_NACK : MODE_ACK, BYTE_ZERO,
                        SDA_RAND, noisy);
            end
            else
            begin
                run_cmd(MODE_WRITE, 8'($urandom), SDA_RAND, noisy);
                run_cmd(MODE_RDACK, BYTE_ZERO, SDA_RAND, noisy);
            end
        end
        if ($urandom_range(0, 4) != 0)
            run_cmd(MODE_STOP, BYTE_ZERO, SDA_RAND, noisy);
    endtask

    task automatic test_random_traffic();
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                settle();
                write_cfg(CFG_IDX_PHASE, 16'($urandom_range(0, 3)));
                write_cfg(CFG_IDX_RELEASE, 16'($urandom_range(0, 6)));
            end
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle <= ($urandom_range(0, 3) != 0);
            random_transfer();
        end
        settle();
    endtask

    initial
    begin
        bus_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_commands();
        test_zero_hold();
        test_longest_hold();
        test_backpressure();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
